[rtl/pcoc_pkg.sv]
// Package for the phase current offset calibrator.
// Holds widths, register reset values, register index codes and the saturation helper.
// No dependencies.
package pcoc_pkg;

    // Converter sample width and the fixed-point widths that follow from it.
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int OFFSET_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int DIFF_BITS   = OFFSET_BITS + 1;

    // Configuration register widths and reset values.
    localparam int GAIN_BITS      = 16;
    localparam int APC_BITS       = 24;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(655);
    localparam logic [APC_BITS-1:0]  APC_RESET  = APC_BITS'(659);

    // Multiplier operand and product widths.
    localparam int COEF_BITS  = APC_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + COEF_BITS;
    localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;

    // Current width, Q16.16 amps.
    localparam int CUR_BITS = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FILTER_GAIN    = 1'b0,
        CFG_AMPS_PER_COUNT = 1'b1
    } cfg_index_t;

    // Clamp a wide signed value to the signed current range.
    function automatic logic signed [CUR_BITS-1:0] sat_cur(
        input logic signed [SHIFT_BITS-1:0] x
    );
        logic                         sgn;
        logic [SHIFT_BITS-CUR_BITS:0] upper;
        logic signed [CUR_BITS-1:0]   res;
        sgn   = x[SHIFT_BITS-1];
        upper = x[SHIFT_BITS-1:CUR_BITS-1];
        if (!sgn && (|upper))
        begin
            res = {1'b0, {(CUR_BITS-1){1'b1}}};
        end
        else if (sgn && !(&upper))
        begin
            res = {1'b1, {(CUR_BITS-1){1'b0}}};
        end
        else
        begin
            res = x[CUR_BITS-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/phase_current_offset_calibrator.sv]
// Top level of the phase current offset calibrator: input register, shared
// multiplier datapath, offset and current state, result register.
// Depends on pcoc_pkg.
//
//  Channel | Handshake                    | Payload
//  --------+------------------------------+-------------------------------------------
//  input   | in_valid  / in_stall (out)   | sample, phase_select, counting_down
//  output  | out_valid / out_stall (in)   | current_u, current_v, current_w, calibrating
//  config  | cfg_write                    | cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low; its result is registered
// in the result register as it leaves the input register. The single multiply is fed
// straight from the offset registers, so a later transaction sees the state it leaves.
// Reset clears offsets, currents and valid flags and restores the register defaults.
// A stalled result holds the input stage; in_stall rises only when both stages are full.
module phase_current_offset_calibrator
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pcoc_pkg::SAMPLE_BITS-1:0]       sample,
    input  logic                                   phase_select,
    input  logic                                   counting_down,
    // Output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pcoc_pkg::CUR_BITS-1:0]   current_u,
    output logic signed [pcoc_pkg::CUR_BITS-1:0]   current_v,
    output logic signed [pcoc_pkg::CUR_BITS-1:0]   current_w,
    output logic                                   calibrating,
    // Configuration port
    input  logic                                   cfg_write,
    input  logic [pcoc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [pcoc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import pcoc_pkg::*;

    // Configuration registers
    logic [GAIN_BITS-1:0] filter_gain_reg;
    logic [APC_BITS-1:0]  amps_per_count_reg;

    // Input stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_phase_reg;
    logic                   s1_down_reg;

    // State and result stage
    logic [OFFSET_BITS-1:0]     offset_w_reg, offset_w_next;
    logic [OFFSET_BITS-1:0]     offset_v_reg, offset_v_next;
    logic signed [CUR_BITS-1:0] meas_w_reg, meas_w_next;
    logic signed [CUR_BITS-1:0] meas_v_reg, meas_v_next;
    logic signed [CUR_BITS-1:0] meas_u_reg, meas_u_next;
    logic                       out_valid_reg;
    logic                       calibrating_reg;

    // Datapath
    logic                         out_load;
    logic                         s1_advance;
    logic [OFFSET_BITS-1:0]       off_sel;
    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [COEF_BITS-1:0]  coef;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [SHIFT_BITS-1:0] shifted;
    logic signed [CUR_BITS-1:0]   cur;
    logic signed [SHIFT_BITS-1:0] u_sum;

    // Flow control: the result register loads when empty or being taken.
    assign out_load   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_load;
    assign in_stall   = s1_valid_reg && !out_load;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_gain_reg    <= GAIN_RESET;
            amps_per_count_reg <= APC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FILTER_GAIN:    filter_gain_reg    <= cfg_data[GAIN_BITS-1:0];
                CFG_AMPS_PER_COUNT: amps_per_count_reg <= cfg_data[APC_BITS-1:0];
            endcase
        end
    end

    // Input register; the valid flag is control state, the payload is not reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_sample_reg <= sample;
            s1_phase_reg  <= phase_select;
            s1_down_reg   <= counting_down;
        end
    end

    // Shared multiplier: the difference from the offset times either K or the gain.
    always_comb
    begin
        off_sel = s1_phase_reg ? offset_v_reg : offset_w_reg;
        diff    = $signed({1'b0, s1_sample_reg, {FRAC_BITS{1'b0}}})
                - $signed({1'b0, off_sel});
        if (s1_down_reg)
        begin
            coef = $signed({{(COEF_BITS-GAIN_BITS){1'b0}}, filter_gain_reg});
        end
        else
        begin
            coef = $signed({1'b0, amps_per_count_reg});
        end
        prod    = diff * coef;
        shifted = prod[PROD_BITS-1:FRAC_BITS];
        cur     = sat_cur(shifted);
    end

    // Next state: a calibration transaction moves one offset, a measurement
    // transaction replaces one current and recomputes phase U.
    always_comb
    begin
        offset_w_next = offset_w_reg;
        offset_v_next = offset_v_reg;
        meas_w_next   = meas_w_reg;
        meas_v_next   = meas_v_reg;
        if (s1_down_reg)
        begin
            if (s1_phase_reg)
            begin
                offset_v_next = off_sel + shifted[OFFSET_BITS-1:0];
            end
            else
            begin
                offset_w_next = off_sel + shifted[OFFSET_BITS-1:0];
            end
        end
        else if (s1_phase_reg)
        begin
            meas_v_next = cur;
        end
        else
        begin
            meas_w_next = cur;
        end
        u_sum = -SHIFT_BITS'(meas_w_next) - SHIFT_BITS'(meas_v_next);
        if (s1_down_reg)
        begin
            meas_u_next = meas_u_reg;
        end
        else
        begin
            meas_u_next = sat_cur(u_sum);
        end
    end

    // State and result register, updated together as a transaction leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_w_reg    <= '0;
            offset_v_reg    <= '0;
            meas_w_reg      <= '0;
            meas_v_reg      <= '0;
            meas_u_reg      <= '0;
            out_valid_reg   <= 1'b0;
            calibrating_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                offset_w_reg    <= offset_w_next;
                offset_v_reg    <= offset_v_next;
                meas_w_reg      <= meas_w_next;
                meas_v_reg      <= meas_v_next;
                meas_u_reg      <= meas_u_next;
                calibrating_reg <= s1_down_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign current_u   = meas_u_reg;
    assign current_v   = meas_v_reg;
    assign current_w   = meas_w_reg;
    assign calibrating = calibrating_reg;

    // A calibration transaction leaves every current as it was.
    a_cal_holds_currents: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_down_reg) |=>
            ($stable(meas_u_reg) && $stable(meas_v_reg) && $stable(meas_w_reg))
    ) else $error("calibration transaction changed a current");

    // Offsets move only when a calibration transaction is processed.
    a_offsets_only_on_cal: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(s1_advance && s1_down_reg) |=>
            ($stable(offset_w_reg) && $stable(offset_v_reg))
    ) else $error("offset changed outside a calibration transaction");

    // A measurement result always carries U consistent with the held V and W.
    a_u_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !calibrating_reg) |->
            (meas_u_reg == sat_cur(-SHIFT_BITS'(meas_w_reg) - SHIFT_BITS'(meas_v_reg)))
    ) else $error("phase U current inconsistent with V and W");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for phase_current_offset_calibrator.
// Keeps its own copy of the offsets, currents and registers to predict every result.
// Depends on pcoc_pkg and the RTL top level.
module tb_top;
    import pcoc_pkg::*;

    // Field codes and run limits.
    localparam logic   PHASE_W          = 1'b0;
    localparam logic   PHASE_V          = 1'b1;
    localparam logic   WINDOW_MEASURE   = 1'b0;
    localparam logic   WINDOW_CALIBRATE = 1'b1;
    localparam int     STUCK_LIMIT      = 2000;
    localparam int     HOLD_OFF_CYCLES  = 40;
    localparam longint CUR_MAX          = 64'sd2147483647;
    localparam longint CUR_MIN          = -64'sd2147483648;

    typedef struct {
        logic signed [CUR_BITS-1:0] u;
        logic signed [CUR_BITS-1:0] v;
        logic signed [CUR_BITS-1:0] w;
        logic                       cal;
    } currents_t;

    // Block ports.
    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_stall;
    logic [SAMPLE_BITS-1:0]     sample        = '0;
    logic                       phase_select  = PHASE_W;
    logic                       counting_down = WINDOW_MEASURE;
    logic                       out_valid;
    logic                       out_stall     = 1'b0;
    logic signed [CUR_BITS-1:0] current_u;
    logic signed [CUR_BITS-1:0] current_v;
    logic signed [CUR_BITS-1:0] current_w;
    logic                       calibrating;
    logic                       cfg_write     = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index     = CFG_FILTER_GAIN;
    logic [CFG_DATA_BITS-1:0]   cfg_data      = '0;

    // Predicted state of the block.
    logic [GAIN_BITS-1:0]       filt_coef    = GAIN_RESET;
    logic [APC_BITS-1:0]        amps_coef    = APC_RESET;
    logic [OFFSET_BITS-1:0]     offset_w_est = '0;
    logic [OFFSET_BITS-1:0]     offset_v_est = '0;
    logic signed [CUR_BITS-1:0] phase_w_amps = '0;
    logic signed [CUR_BITS-1:0] phase_v_amps = '0;
    logic signed [CUR_BITS-1:0] phase_u_amps = '0;

    // Shared control of the run.
    currents_t expected_currents[$];
    bit        sender_idling    = 1'b1;
    bit        receiver_idling  = 1'b1;
    int        hold_off_request = 0;
    int        error_count      = 0;

    phase_current_offset_calibrator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .phase_select  (phase_select),
        .counting_down (counting_down),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_u     (current_u),
        .current_v     (current_v),
        .current_w     (current_w),
        .calibrating   (calibrating),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a wide value to the signed 32-bit current range.
    function automatic logic signed [CUR_BITS-1:0] clamp_current(input longint x);
        if (x > CUR_MAX)
            return CUR_MAX[CUR_BITS-1:0];
        if (x < CUR_MIN)
            return CUR_MIN[CUR_BITS-1:0];
        return x[CUR_BITS-1:0];
    endfunction

    // Update the predicted offsets or currents for one transaction and queue its result.
    // Arithmetic shifts of signed values give the floor division by 2^16.
    function automatic void predict_currents(input logic [SAMPLE_BITS-1:0] smp,
                                             input logic is_v, input logic window);
        longint    smp_q16;
        longint    off;
        longint    diff;
        longint    coef;
        currents_t want;
        smp_q16 = smp;
        smp_q16 = smp_q16 << FRAC_BITS;
        off     = is_v ? offset_v_est : offset_w_est;
        diff    = smp_q16 - off;
        if (window == WINDOW_CALIBRATE)
        begin
            coef = filt_coef;
            off  = off + ((diff * coef) >>> FRAC_BITS);
            if (is_v)
                offset_v_est = off[OFFSET_BITS-1:0];
            else
                offset_w_est = off[OFFSET_BITS-1:0];
        end
        else
        begin
            coef = amps_coef;
            if (is_v)
                phase_v_amps = clamp_current((diff * coef) >>> FRAC_BITS);
            else
                phase_w_amps = clamp_current((diff * coef) >>> FRAC_BITS);
            phase_u_amps = clamp_current(-longint'(phase_w_amps) - longint'(phase_v_amps));
        end
        want.u   = phase_u_amps;
        want.v   = phase_v_amps;
        want.w   = phase_w_amps;
        want.cal = window;
        expected_currents.push_back(want);
    endfunction

    // Print one line for each mismatch and count it.
    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, field, got, want);
        error_count++;
    endtask

    // Offer one transaction, optionally after a random idle burst, and wait for acceptance.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic is_v,
                               input logic window);
        int gap;
        if (sender_idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        sample        <= smp;
        phase_select  <= is_v;
        counting_down <= window;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_currents(smp, is_v, window);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_currents.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_FILTER_GAIN)
            filt_coef = data[GAIN_BITS-1:0];
        else
            amps_coef = data[APC_BITS-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Registers are only written once the block has gone idle.
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] gain_word,
                              input logic [CFG_DATA_BITS-1:0] apc_word);
        drain_results();
        write_register(CFG_FILTER_GAIN, gain_word);
        write_register(CFG_AMPS_PER_COUNT, apc_word);
    endtask

    // A sample close to a zero-current level, kept inside the converter range.
    function automatic logic [SAMPLE_BITS-1:0] near_level(input int level, input int spread);
        int x;
        x = level + $urandom_range(0, 2 * spread) - spread;
        if (x < 0)
            x = 0;
        if (x > 4095)
            x = 4095;
        return x[SAMPLE_BITS-1:0];
    endfunction

    // One PWM period: both phases calibrate while counting down, then measure counting up.
    task automatic pwm_cycle(input int level);
        send_sample(near_level(level, 8), PHASE_W, WINDOW_CALIBRATE);
        send_sample(near_level(level, 8), PHASE_V, WINDOW_CALIBRATE);
        send_sample(near_level(level, $urandom_range(0, 1) ? 2048 : 300), PHASE_W,
                    WINDOW_MEASURE);
        send_sample(near_level(level, $urandom_range(0, 1) ? 2048 : 300), PHASE_V,
                    WINDOW_MEASURE);
    endtask

    // Mostly PWM periods around a drifting level, with some fully random transactions.
    task automatic random_traffic(input int count);
        int level;
        int sent;
        level = $urandom_range(0, 4095);
        sent  = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pwm_cycle(level);
                sent += 4;
            end
            else
            begin
                send_sample(SAMPLE_BITS'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 31) == 0)
                level = $urandom_range(0, 4095);
        end
    endtask

    // Register defaults and zero offsets straight after reset.
    task automatic test_reset_defaults();
        send_sample(12'd0, PHASE_W, WINDOW_MEASURE);
        send_sample(12'd4095, PHASE_V, WINDOW_MEASURE);
        send_sample(12'd2048, PHASE_W, WINDOW_CALIBRATE);
        send_sample(12'd2048, PHASE_V, WINDOW_CALIBRATE);
    endtask

    // Largest and zero filter coefficient; upper data bits beyond the field are ignored.
    task automatic test_offset_filter();
        set_config(24'hFFFFFF, 24'd659);
        repeat (3) send_sample(12'd4095, PHASE_W, WINDOW_CALIBRATE);
        send_sample(12'd0, PHASE_V, WINDOW_CALIBRATE);
        send_sample(12'd4095, PHASE_W, WINDOW_MEASURE);
        send_sample(12'd0, PHASE_V, WINDOW_MEASURE);
        set_config(24'hFF0000, 24'd659);
        send_sample(12'd0, PHASE_W, WINDOW_CALIBRATE);
        send_sample(12'd4095, PHASE_W, WINDOW_MEASURE);
    endtask

    // Phase currents at both rails, and the U current clamped from both sides.
    task automatic test_current_saturation();
        set_config(24'h00FFFF, 24'hFFFFFF);
        send_sample(12'd0, PHASE_W, WINDOW_CALIBRATE);
        send_sample(12'd0, PHASE_V, WINDOW_CALIBRATE);
        send_sample(12'd4095, PHASE_W, WINDOW_MEASURE);
        send_sample(12'd4095, PHASE_V, WINDOW_MEASURE);
        send_sample(12'd4095, PHASE_W, WINDOW_CALIBRATE);
        send_sample(12'd4095, PHASE_V, WINDOW_CALIBRATE);
        send_sample(12'd0, PHASE_W, WINDOW_MEASURE);
        send_sample(12'd0, PHASE_V, WINDOW_MEASURE);
    endtask

    // A zero current scale gives zero on every measured phase.
    task automatic test_zero_amps_per_count();
        set_config(24'd655, 24'd0);
        send_sample(12'd4095, PHASE_W, WINDOW_MEASURE);
        send_sample(12'd0, PHASE_V, WINDOW_MEASURE);
    endtask

    // Random traffic under a series of register settings, the extremes first.
    task automatic test_random_settings();
        logic [GAIN_BITS-1:0] gain;
        logic [APC_BITS-1:0]  apc;
        for (int p = 0; p < 6; p++)
        begin
            gain = GAIN_BITS'($urandom_range(0, 65535));
            apc  = ($urandom_range(0, 3) == 0) ? APC_BITS'($urandom_range(1, 24'hFFFFFF))
                                               : APC_BITS'($urandom_range(1, 4000));
            if (p == 0)
            begin
                gain = '0;
                apc  = APC_BITS'(1);
            end
            else if (p == 1)
            begin
                gain = '1;
                apc  = '1;
            end
            set_config({8'($urandom_range(0, 255)), gain}, apc);
            random_traffic(180);
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_input_backpressure();
        sender_idling    = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        random_traffic(40);
        sender_idling    = 1'b1;
    endtask

    // The sender waits for every outstanding result before carrying on.
    task automatic test_sender_pause();
        random_traffic(40);
        drain_results();
        random_traffic(40);
    endtask

    // Back-to-back transactions with no idling on either side.
    task automatic test_steady_stream();
        set_config(24'd655, 24'd659);
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        random_traffic(180);
    endtask

    // Receiver stall: a requested long hold-off, otherwise random stall bursts.
    initial
    begin : result_stall
        int burst;
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                burst            = hold_off_request;
                hold_off_request = 0;
                out_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else if (receiver_idling && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        currents_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_currents.size() == 0)
                report_mismatch("unexpected result transaction", 0, 0);
            else
            begin
                want = expected_currents.pop_front();
                if (current_u !== want.u)
                    report_mismatch("current_u", current_u, want.u);
                if (current_v !== want.v)
                    report_mismatch("current_v", current_v, want.v);
                if (current_w !== want.w)
                    report_mismatch("current_w", current_w, want.w);
                if (calibrating !== want.cal)
                    report_mismatch("calibrating", calibrating, want.cal);
            end
        end
    end

    // End the run if nothing moves on any port for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0) || cfg_write || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_offset_filter();
        test_current_saturation();
        test_zero_amps_per_count();
        test_random_settings();
        test_input_backpressure();
        test_sender_pause();
        test_steady_stream();
        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_currents.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
